// ===== rtl/cobs_ftr_pkg.sv =====
`default_nettype none

package cobs_ftr_pkg;

    // result kinds (tuser)
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_CHUNK_OK = 2'd1;
    localparam logic [1:0] KIND_XFER_OK  = 2'd2;
    localparam logic [1:0] KIND_XFER_ERR = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_RX_FRAME    = 4'd1;
    localparam logic [3:0] ERR_BEGIN_SHORT = 4'd2;
    localparam logic [3:0] ERR_BEGIN_HDR   = 4'd3;
    localparam logic [3:0] ERR_BEGIN_NAME  = 4'd4;
    localparam logic [3:0] ERR_FRAME_SHORT = 4'd5;
    localparam logic [3:0] ERR_DATA_SHORT  = 4'd6;
    localparam logic [3:0] ERR_SEQUENCE    = 4'd7;
    localparam logic [3:0] ERR_DATA_CHUNK  = 4'd8;
    localparam logic [3:0] ERR_OVERSIZE    = 4'd9;
    localparam logic [3:0] ERR_BAD_TYPE    = 4'd10;
    localparam logic [3:0] ERR_SIZE        = 4'd11;
    localparam logic [3:0] ERR_HASH        = 4'd12;

    // frame types
    localparam logic [7:0] TYPE_BEGIN = 8'd1;
    localparam logic [7:0] TYPE_DATA  = 8'd2;
    localparam logic [7:0] TYPE_END   = 8'd3;

    // frame header lengths
    localparam logic [16:0] HDR_COMMON = 17'd5;
    localparam logic [16:0] HDR_DATA   = 17'd7;
    localparam logic [16:0] HDR_BEGIN  = 17'd15;

    localparam logic [31:0] HASH_SEED = 32'h1234_5678;

    // h*33 xor b
    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        hash_step = ((h << 5) + h) ^ {24'd0, b};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cobs_file_transfer_receiver.sv =====
// A result word is registered and appears on the master side in the cycle after its link byte is taken.
// Throughput: one link byte per cycle; the state update is a single pass of decode,
// compare and shift-add hash logic between the state registers and the result register.
// s_axis_tready drops only while a result word waits and m_axis_tready is low.
// Reset (i_rst_n low, synchronous) clears all control and transfer state.
`default_nettype none

module cobs_file_transfer_receiver
    import cobs_ftr_pkg::*;
#(
    parameter int MAX_ENCODED = 600,
    parameter int MAX_DECODED = 520
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // link bytes in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // results out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [11:8] error_code, [15:12] 0
    output logic [1:0]       m_axis_tuser    // [1:0] result_kind
);

    localparam int ENC_W = $clog2(MAX_ENCODED + 1);
    localparam int DEC_W = $clog2(MAX_DECODED + 1);
    localparam logic [ENC_W-1:0] ENC_LIM = ENC_W'(MAX_ENCODED);
    localparam logic [DEC_W-1:0] DEC_LIM = DEC_W'(MAX_DECODED);

    // transfer and frame state
    logic             r_in_xfer,    n_in_xfer;     // 0: waiting for BEGIN
    logic [ENC_W-1:0] r_enc_cnt,    n_enc_cnt;
    logic [DEC_W-1:0] r_dec_cnt,    n_dec_cnt;
    logic [7:0]       r_grp_left,   n_grp_left;
    logic             r_grp_full,   n_grp_full;
    logic             r_broken,     n_broken;
    logic [7:0]       r_frm_type,   n_frm_type;
    logic [31:0]      r_frm_seq,    n_frm_seq;
    logic [15:0]      r_len_field,  n_len_field;
    logic [31:0]      r_total_size, n_total_size;
    logic [31:0]      r_exp_hash,   n_exp_hash;
    logic [31:0]      r_next_seq,   n_next_seq;
    logic [31:0]      r_bytes_rx,   n_bytes_rx;
    logic [31:0]      r_commit_h,   n_commit_h;
    logic [31:0]      r_tent_h,     n_tent_h;

    // result register
    logic             r_out_valid,  n_out_valid;
    logic [1:0]       r_out_kind,   n_out_kind;
    logic [7:0]       r_out_data,   n_out_data;
    logic [3:0]       r_out_err,    n_out_err;

    logic in_accept;

    // a new byte can go in whenever the result slot is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_err, r_out_data};
    assign m_axis_tuser  = r_out_kind;

    always_comb begin
        logic [7:0]       b;
        logic             take;
        logic [7:0]       take_byte;
        logic             brk;
        logic [DEC_W-1:0] len;
        logic [16:0]      len17;
        logic [16:0]      idx17;
        logic [16:0]      rel;
        logic [31:0]      sum;
        logic             fail;
        logic [3:0]       fail_code;
        logic             restart;

        b         = s_axis_tdata;
        take      = 1'b0;
        take_byte = 8'd0;
        brk       = 1'b0;
        len       = '0;
        len17     = '0;
        idx17     = '0;
        rel       = '0;
        sum       = '0;
        fail      = 1'b0;
        fail_code = ERR_NONE;
        restart   = 1'b0;

        n_in_xfer    = r_in_xfer;
        n_enc_cnt    = r_enc_cnt;
        n_dec_cnt    = r_dec_cnt;
        n_grp_left   = r_grp_left;
        n_grp_full   = r_grp_full;
        n_broken     = r_broken;
        n_frm_type   = r_frm_type;
        n_frm_seq    = r_frm_seq;
        n_len_field  = r_len_field;
        n_total_size = r_total_size;
        n_exp_hash   = r_exp_hash;
        n_next_seq   = r_next_seq;
        n_bytes_rx   = r_bytes_rx;
        n_commit_h   = r_commit_h;
        n_tent_h     = r_tent_h;

        n_out_valid  = 1'b0;
        n_out_kind   = KIND_PAYLOAD;
        n_out_data   = 8'd0;
        n_out_err    = ERR_NONE;

        if (b == 8'd0) begin
            // delimiter: check the frame just closed
            brk   = r_broken || (r_grp_left != 8'd0);
            len   = brk ? '0 : r_dec_cnt;
            len17 = 17'(len);
            if (r_enc_cnt == '0) begin
                fail = 1'b1; fail_code = ERR_RX_FRAME;
            end else if (!r_in_xfer) begin
                if (len17 < HDR_BEGIN) begin
                    fail = 1'b1; fail_code = ERR_BEGIN_SHORT;
                end else if (r_frm_type != TYPE_BEGIN || r_frm_seq != 32'd0) begin
                    fail = 1'b1; fail_code = ERR_BEGIN_HDR;
                end else if (len17 < HDR_BEGIN + {1'b0, r_len_field}) begin
                    fail = 1'b1; fail_code = ERR_BEGIN_NAME;
                end else begin
                    restart = 1'b1;
                end
            end else if (len17 < HDR_COMMON) begin
                fail = 1'b1; fail_code = ERR_FRAME_SHORT;
            end else if (r_frm_type == TYPE_DATA) begin
                sum = r_bytes_rx + {16'd0, r_len_field};
                if (len17 < HDR_DATA) begin
                    fail = 1'b1; fail_code = ERR_DATA_SHORT;
                end else if (r_frm_seq != r_next_seq) begin
                    fail = 1'b1; fail_code = ERR_SEQUENCE;
                end else if (len17 < HDR_DATA + {1'b0, r_len_field}) begin
                    fail = 1'b1; fail_code = ERR_DATA_CHUNK;
                end else if (sum > r_total_size) begin
                    fail = 1'b1; fail_code = ERR_OVERSIZE;
                end else begin
                    // chunk confirmed
                    n_bytes_rx  = sum;
                    n_next_seq  = r_next_seq + 32'd1;
                    n_commit_h  = r_tent_h;
                    n_tent_h    = r_tent_h;
                    n_enc_cnt   = '0;
                    n_dec_cnt   = '0;
                    n_grp_left  = 8'd0;
                    n_grp_full  = 1'b0;
                    n_broken    = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CHUNK_OK;
                end
            end else if (r_frm_type == TYPE_END) begin
                if (r_bytes_rx != r_total_size) begin
                    fail = 1'b1; fail_code = ERR_SIZE;
                end else if (r_commit_h != r_exp_hash) begin
                    fail = 1'b1; fail_code = ERR_HASH;
                end else begin
                    restart     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_XFER_OK;
                end
            end else begin
                fail = 1'b1; fail_code = ERR_BAD_TYPE;
            end
        end else if (r_enc_cnt >= ENC_LIM) begin
            // frame too long
            fail = 1'b1; fail_code = ERR_RX_FRAME;
        end else begin
            n_enc_cnt = r_enc_cnt + ENC_W'(1);
            if (r_grp_left == 8'd0) begin
                // group code byte; a short previous group implies a zero
                take       = (r_enc_cnt != '0) && !r_grp_full;
                take_byte  = 8'd0;
                n_grp_left = b - 8'd1;
                n_grp_full = (b == 8'hFF);
            end else begin
                take       = 1'b1;
                take_byte  = b;
                n_grp_left = r_grp_left - 8'd1;
            end
        end

        // one decoded byte into the frame fields
        if (take && !r_broken) begin
            if (r_dec_cnt >= DEC_LIM) begin
                n_broken = 1'b1;
            end else begin
                n_dec_cnt = r_dec_cnt + DEC_W'(1);
                idx17     = 17'(r_dec_cnt);
                rel       = idx17 - 17'd7;
                if (idx17 == 17'd0) begin
                    n_frm_type = take_byte;
                end else if (idx17 <= 17'd4) begin
                    n_frm_seq[8*(2'(idx17 - 17'd1)) +: 8] = take_byte;
                end else if (idx17 <= 17'd6) begin
                    n_len_field[8*(1'(idx17 - 17'd5)) +: 8] = take_byte;
                end else if (!r_in_xfer) begin
                    if (idx17 <= 17'd10) begin
                        n_total_size[8*(2'(idx17 - 17'd7)) +: 8] = take_byte;
                    end else if (idx17 <= 17'd14) begin
                        n_exp_hash[8*(2'(idx17 - 17'd11)) +: 8] = take_byte;
                    end
                end else if (r_frm_type == TYPE_DATA && rel < {1'b0, r_len_field}) begin
                    // tentative payload byte
                    n_tent_h    = hash_step(r_tent_h, take_byte);
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_PAYLOAD;
                    n_out_data  = take_byte;
                end
            end
        end

        // failure or a finished transfer: back to waiting, BEGIN accepted: receiving
        if (fail || restart) begin
            n_in_xfer  = restart && !r_in_xfer;
            n_next_seq = 32'd1;
            n_bytes_rx = 32'd0;
            n_commit_h = HASH_SEED;
            n_tent_h   = HASH_SEED;
            n_enc_cnt  = '0;
            n_dec_cnt  = '0;
            n_grp_left = 8'd0;
            n_grp_full = 1'b0;
            n_broken   = 1'b0;
        end
        if (fail) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_XFER_ERR;
            n_out_data  = 8'd0;
            n_out_err   = fail_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_xfer    <= 1'b0;
            r_enc_cnt    <= '0;
            r_dec_cnt    <= '0;
            r_grp_left   <= 8'd0;
            r_grp_full   <= 1'b0;
            r_broken     <= 1'b0;
            r_frm_type   <= 8'd0;
            r_frm_seq    <= 32'd0;
            r_len_field  <= 16'd0;
            r_total_size <= 32'd0;
            r_exp_hash   <= 32'd0;
            r_next_seq   <= 32'd1;
            r_bytes_rx   <= 32'd0;
            r_commit_h   <= HASH_SEED;
            r_tent_h     <= HASH_SEED;
            r_out_valid  <= 1'b0;
        end else if (in_accept) begin
            r_in_xfer    <= n_in_xfer;
            r_enc_cnt    <= n_enc_cnt;
            r_dec_cnt    <= n_dec_cnt;
            r_grp_left   <= n_grp_left;
            r_grp_full   <= n_grp_full;
            r_broken     <= n_broken;
            r_frm_type   <= n_frm_type;
            r_frm_seq    <= n_frm_seq;
            r_len_field  <= n_len_field;
            r_total_size <= n_total_size;
            r_exp_hash   <= n_exp_hash;
            r_next_seq   <= n_next_seq;
            r_bytes_rx   <= n_bytes_rx;
            r_commit_h   <= n_commit_h;
            r_tent_h     <= n_tent_h;
            r_out_valid  <= n_out_valid;
        end else if (m_axis_tready) begin
            r_out_valid  <= 1'b0;
        end
    end

    // result payload, loaded with each accepted byte
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
            r_out_err  <= n_out_err;
        end
    end

endmodule

`default_nettype wire
